// ----- src/smi_pkg.sv -----
`timescale 1ns / 1ps
// smi_pkg: shared types, codes and constants of the safety mode interlock
// no dependencies; imported by every module of the block

package smi_pkg;

   // default width of the latched fault word
   localparam int FAULT_WIDTH_DEFAULT = 8;

   // configuration port geometry: one 32-bit register at byte address 0
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_WORD_LSB   = 2;

   // register index within the word-address space
   localparam logic REG_LOW_VOLTAGE = 1'b0;

   // battery floor at or below which no low-voltage fault is raised
   localparam logic [15:0] BATTERY_FLOOR_MV = 16'd1000;

   // live fault bit positions
   localparam int FAULT_BIT_LEAK = 0;
   localparam int FAULT_BIT_IMU  = 1;
   localparam int FAULT_BIT_LOWV = 2;

   typedef enum logic [1:0] {
      MODE_STANDBY  = 2'd0,
      MODE_DISARMED = 2'd1,
      MODE_ARMED    = 2'd2,
      MODE_FAILSAFE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CMD_REQUEST  = 2'd0,
      CMD_FAILSAFE = 2'd1,
      CMD_INIT     = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK                 = 3'd0,
      ST_INVALID_PARAM      = 3'd1,
      ST_INVALID_TRANSITION = 3'd2,
      ST_FAULT_LATCHED      = 3'd3,
      ST_SAFETY_BLOCKED     = 3'd4
   } status_type;

   // decision handed from the interlock logic to the result stage
   typedef struct packed {
      status_type status;
      mode_type   mode;
   } decision_type;

endpackage

// ----- src/smi_if.sv -----
`timescale 1ns / 1ps
// smi_if: valid/ready channel interfaces for command items and result items
// no dependencies

interface smi_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [1:0]  target_mode;
   logic        leak_detected;
   logic        imu_error;
   logic [15:0] battery_mv;
   logic [7:0]  failsafe_faults;

   modport source (
      output valid, command, target_mode, leak_detected, imu_error,
             battery_mv, failsafe_faults,
      input  ready
   );
   modport sink (
      input  valid, command, target_mode, leak_detected, imu_error,
             battery_mv, failsafe_faults,
      output ready
   );
endinterface

interface smi_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [1:0] current_mode;
   logic [7:0] fault_word;

   modport source (
      output valid, status, current_mode, fault_word,
      input  ready
   );
   modport sink (
      input  valid, status, current_mode, fault_word,
      output ready
   );
endinterface

// ----- src/smi_csr.sv -----
`timescale 1ns / 1ps
// smi_csr: APB-style register file holding the low-voltage threshold
// depends on smi_pkg

module smi_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [smi_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [smi_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [smi_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready,
   output logic [15:0]                        low_voltage_mv
);
   import smi_pkg::*;

   logic        word_index;
   logic        write_en;
   logic [15:0] low_voltage_ff;
   logic [15:0] low_voltage_in;

   // word index from the byte address
   assign word_index = csr_paddr[CSR_WORD_LSB];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // threshold register update
   always_comb begin
      low_voltage_in = low_voltage_ff;
      if (write_en && (word_index == REG_LOW_VOLTAGE)) begin
         low_voltage_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_voltage_ff <= '0;
      end else begin
         low_voltage_ff <= low_voltage_in;
      end
   end

   // read mux
   always_comb begin
      csr_prdata = '0;
      if (word_index == REG_LOW_VOLTAGE) begin
         csr_prdata = CSR_DATA_WIDTH'(low_voltage_ff);
      end
   end

   assign low_voltage_mv = low_voltage_ff;

endmodule

// ----- src/smi_decide.sv -----
`timescale 1ns / 1ps
// smi_decide: mode transition rules, arming interlock and fault latching
// depends on smi_pkg

module smi_decide #(
   parameter int FAULT_WIDTH = smi_pkg::FAULT_WIDTH_DEFAULT
) (
   input  smi_pkg::mode_type     mode,
   input  logic [FAULT_WIDTH-1:0] faults,
   input  logic [1:0]            command,
   input  logic [1:0]            target_mode,
   input  logic                  leak_detected,
   input  logic                  imu_error,
   input  logic [15:0]           battery_mv,
   input  logic [7:0]            failsafe_faults,
   input  logic [15:0]           low_voltage_mv,
   output smi_pkg::decision_type decision,
   output logic [FAULT_WIDTH-1:0] faults_next
);
   import smi_pkg::*;

   logic [FAULT_WIDTH-1:0] live;
   logic [FAULT_WIDTH-1:0] entry_faults;
   mode_type               target;

   // live faults from the sensor flags and battery window
   always_comb begin
      live                 = '0;
      live[FAULT_BIT_LEAK] = leak_detected;
      live[FAULT_BIT_IMU]  = imu_error;
      live[FAULT_BIT_LOWV] = (battery_mv > BATTERY_FLOOR_MV) &&
                             (battery_mv < low_voltage_mv);
   end

   assign entry_faults = FAULT_WIDTH'(32'(failsafe_faults));
   assign target       = mode_type'(target_mode);

   // command decode and transition rules
   always_comb begin
      decision.status = ST_OK;
      decision.mode   = mode;
      faults_next     = faults;
      unique case (cmd_type'(command))
         CMD_REQUEST: begin
            if (mode == MODE_FAILSAFE) begin
               faults_next = live;
               if ((target != MODE_DISARMED) || (live != '0)) begin
                  decision.status = ST_FAULT_LATCHED;
               end else begin
                  faults_next   = '0;
                  decision.mode = MODE_DISARMED;
               end
            end else if (target == MODE_FAILSAFE) begin
               decision.status = ST_INVALID_TRANSITION;
            end else if (target == mode) begin
               decision.status = ST_OK;
            end else if ((target == MODE_ARMED) && (mode != MODE_DISARMED)) begin
               decision.status = ST_INVALID_TRANSITION;
            end else if ((target == MODE_ARMED) && (live != '0)) begin
               decision.status = ST_SAFETY_BLOCKED;
            end else begin
               decision.mode = target;
            end
         end
         CMD_FAILSAFE: begin
            if (entry_faults == '0) begin
               decision.status = ST_INVALID_PARAM;
            end else begin
               faults_next   = faults | entry_faults;
               decision.mode = MODE_FAILSAFE;
            end
         end
         CMD_INIT: begin
            decision.mode = target;
            faults_next   = '0;
         end
         default: begin
            decision.status = ST_INVALID_PARAM;
         end
      endcase
   end

endmodule

// ----- src/safety_mode_interlock.sv -----
`timescale 1ns / 1ps
// safety_mode_interlock: each command passes from the input register through the
// interlock logic into the result register; throughput one command per cycle
// unless a held result stalls it; mode and faults update as the item leaves
// the input register, so consecutive items see each other's effects
// reset (synchronous, active high): standby mode, no faults, threshold 0,
// both pipeline stages empty

module safety_mode_interlock #(
   parameter int FAULT_WIDTH = smi_pkg::FAULT_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   smi_req_if.sink                            req_chan,
   smi_rsp_if.source                          rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [smi_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [smi_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [smi_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);
   import smi_pkg::*;

   logic [15:0] low_voltage_mv;

   // input register
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [1:0]  cmd_ff;
   logic [1:0]  req_mode_ff;
   logic        leak_ff;
   logic        imu_ff;
   logic [15:0] battery_ff;
   logic [7:0]  entry_faults_ff;

   // interlock state
   mode_type               mode_ff;
   mode_type               mode_in;
   logic [FAULT_WIDTH-1:0] faults_ff;
   logic [FAULT_WIDTH-1:0] faults_in;

   // result register
   logic       out_valid_ff;
   logic       out_valid_in;
   status_type out_status_ff;
   mode_type   out_mode_ff;
   logic [7:0] out_faults_ff;

   decision_type           decision;
   logic [FAULT_WIDTH-1:0] faults_next;
   logic                   advance;
   logic                   take;

   smi_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .low_voltage_mv (low_voltage_mv)
   );

   smi_decide #(
      .FAULT_WIDTH (FAULT_WIDTH)
   ) u_decide (
      .mode            (mode_ff),
      .faults          (faults_ff),
      .command         (cmd_ff),
      .target_mode     (req_mode_ff),
      .leak_detected   (leak_ff),
      .imu_error       (imu_ff),
      .battery_mv      (battery_ff),
      .failsafe_faults (entry_faults_ff),
      .low_voltage_mv  (low_voltage_mv),
      .decision        (decision),
      .faults_next     (faults_next)
   );

   // pipeline handshake
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      mode_in      = mode_ff;
      faults_in    = faults_ff;
      if (advance) begin
         mode_in   = decision.mode;
         faults_in = faults_next;
      end
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_STANDBY;
         faults_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
         faults_ff    <= faults_in;
      end
   end

   // command payload capture on transfer
   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff          <= req_chan.command;
         req_mode_ff     <= req_chan.target_mode;
         leak_ff         <= req_chan.leak_detected;
         imu_ff          <= req_chan.imu_error;
         battery_ff      <= req_chan.battery_mv;
         entry_faults_ff <= req_chan.failsafe_faults;
      end
   end

   // result payload capture
   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff <= decision.status;
         out_mode_ff   <= decision.mode;
         out_faults_ff <= 8'(32'(faults_next));
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = out_status_ff;
   assign rsp_chan.current_mode = out_mode_ff;
   assign rsp_chan.fault_word   = out_faults_ff;

   // state only moves when an item leaves the input register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(mode_ff) && $stable(faults_ff)))
      else $error("interlock state changed without an item");

   // every processed item produces a pending result
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed item produced no result");

   // a pending result reports the present mode
   a_mode_match: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_mode_ff == mode_ff))
      else $error("result mode differs from interlock mode");

   // fault-latched status only ever comes with failsafe mode
   a_latched_failsafe: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_status_ff == ST_FAULT_LATCHED)) |->
      (out_mode_ff == MODE_FAILSAFE))
      else $error("fault latched outside failsafe");

endmodule
